/* src/tlb_pkg.sv */
// Shared types and constants of the tile light binner.
`timescale 1ns / 1ps
`default_nettype none
package tlb_pkg;

    // Field widths
    localparam int COORD_W   = 13;
    localparam int INDEX_W   = 14;
    localparam int TSIZE_W   = 9;
    localparam int ID_W      = 8;
    localparam int CNT_OUT_W = 9;
    localparam int OFF_OUT_W = 15;
    localparam int RECT_W    = 4 * COORD_W;

    // Divider operand widths
    localparam int DIV_NW = 14;
    localparam int DIV_DW = 9;

    // Commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_RTILE = 2'd2;
    localparam logic [1:0] CMD_RLIST = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_TILE_W = 3'd0;
    localparam logic [2:0] CFG_TILE_H = 3'd1;
    localparam logic [2:0] CFG_VIEW_W = 3'd2;
    localparam logic [2:0] CFG_VIEW_H = 3'd3;
    localparam logic [2:0] CFG_REJ_W  = 3'd4;
    localparam logic [2:0] CFG_REJ_H  = 3'd5;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

/* src/tlb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* src/tlb_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tlb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tlb_pkg::t_div_req i_req,
    output tlb_pkg::t_div_rsp      o_rsp
);

    localparam int NW = tlb_pkg::DIV_NW;
    localparam int DW = tlb_pkg::DIV_DW;

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dsr;

    logic [DW:0]   n_shift;
    logic          n_ge;
    logic [DW:0]   n_rem;

    // One trial subtraction
    always_comb begin
        n_shift = {r_rem[DW-1:0], r_quo[NW-1]};
        n_ge    = (n_shift >= {1'b0, r_dsr});
        n_rem   = n_ge ? (n_shift - {1'b0, r_dsr}) : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_cnt == 4'(NW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NW-2:0], n_ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

/* src/tile_light_binner.sv */
// Top level of the tile light binner: command sequencer, stores and result register.
//
//  channel   dir  signals                         content
//  s_axis    in   tvalid tready tdata[71:0] tuser command in tuser, rect and index in tdata
//  m_axis    out  tvalid tready tdata[63:0]       one result per command
//  cfg       in   i_cfg_we i_cfg_index i_cfg_wdata register writes, no read-back
//
// Load and read commands take one cycle each and can follow back to back while
// the result register drains; a read result is formed from the registered RAM data.
// A build runs two divides, a clear sweep of the count store and two walks over the
// lights with a prefix sweep of the counts between them. Reset clears control and sets the
// configuration defaults; the tile and list stores hold nothing valid until the first
// build. A stalled output holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module tile_light_binner #(
    parameter int MAX_LIGHTS  = 256,
    parameter int MAX_TILES   = 8192,
    parameter int MAX_ENTRIES = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // rect_min_x, rect_min_y, rect_max_x, rect_max_y, index, zero fill
    input  wire logic [71:0] s_axis_tdata,
    // command
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // light_id, tile_light_count, tile_start, max_tile_count, total_entries, status
    output logic      [63:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_wdata
);

    localparam int CW  = 13;
    localparam int LTW = $clog2(MAX_LIGHTS + 1);
    localparam int NCW = $clog2(MAX_LIGHTS + 1);
    localparam int RAW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int TAW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int LAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int PW  = 27;

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_TILE = 2'd1;
    localparam logic [1:0] SRC_LIST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RESP, S_GX, S_GY, S_CLR, S_LRD, S_LGET,
        S_DIV, S_MUL, S_TILE, S_RMW, S_PRD, S_PWR
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [8:0]    r_tw, r_th;
    logic [CW-1:0] r_vw, r_vh, r_rw, r_rh;

    // Persistent state
    logic [LTW-1:0] r_light_total, n_light_total;
    logic [NCW-1:0] r_peak, n_peak;
    logic [EW-1:0]  r_total, n_total;
    logic           r_ovf, n_ovf;

    // Build working registers
    logic [CW-1:0]  r_gx, n_gx, r_gy, n_gy;
    logic [LTW-1:0] r_li, n_li;
    logic [CW-1:0]  r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [1:0]     r_dsel, n_dsel;
    logic [CW-1:0]  r_lx, n_lx, r_ly, n_ly, r_ux, n_ux, r_uy, n_uy;
    logic [CW-1:0]  r_x, n_x, r_y, n_y;
    logic [PW-1:0]  r_rowbase, n_rowbase;
    logic [TAW-1:0] r_t, n_t, r_tile, n_tile;
    logic [EW-1:0]  r_taken, n_taken, r_run, n_run;
    logic           r_pass, n_pass;
    logic [1:0]     r_src, n_src;
    logic [1:0]     r_pstat, n_pstat;

    // Output register
    logic           r_mvalid;
    logic [63:0]    r_mdata;

    // Memory strobes
    logic                 rect_we, rect_re;
    logic [RAW-1:0]       rect_waddr, rect_raddr;
    logic [4*CW-1:0]      rect_rdata;
    logic                 cnt_we, cnt_re;
    logic [TAW-1:0]       cnt_waddr, cnt_raddr;
    logic [NCW-1:0]       cnt_wdata, cnt_rdata;
    logic                 off_we, off_re;
    logic [TAW-1:0]       off_waddr, off_raddr;
    logic [EW-1:0]        off_wdata, off_rdata;
    logic                 lst_we, lst_re;
    logic [LAW-1:0]       lst_waddr, lst_raddr;
    logic [7:0]           lst_wdata, lst_rdata;

    tlb_pkg::t_div_req div_req;
    tlb_pkg::t_div_rsp div_rsp;

    // Helpers
    logic [8:0]     tw_eff, th_eff;
    logic           out_free, acc;
    logic [1:0]     cmd;
    logic [13:0]    idx;
    logic [CW-1:0]  rx0, ry0, rx1, ry1, rw_w, rw_h;
    logic [PW-1:0]  tnum;
    logic [CW-1:0]  qclamp_x, qclamp_y;
    logic [EW-1:0]  psum;
    logic [7:0]     res_id;
    logic [8:0]     res_cnt;
    logic [14:0]    res_start;

    assign tw_eff   = (r_tw == 9'd0) ? 9'd1 : r_tw;
    assign th_eff   = (r_th == 9'd0) ? 9'd1 : r_th;
    assign out_free = !r_mvalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) || ((r_state == S_RESP) && out_free);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign cmd      = s_axis_tuser;
    assign idx      = s_axis_tdata[65:52];

    assign rx0 = rect_rdata[CW-1:0];
    assign ry0 = rect_rdata[2*CW-1:CW];
    assign rx1 = rect_rdata[3*CW-1:2*CW];
    assign ry1 = rect_rdata[4*CW-1:3*CW];
    assign rw_w = (rx1 >= rx0) ? (rx1 - rx0) : '0;
    assign rw_h = (ry1 >= ry0) ? (ry1 - ry0) : '0;

    assign tnum = r_rowbase + PW'(r_x);
    assign psum = r_run + EW'(cnt_rdata);
    assign qclamp_x = (div_rsp.quotient < {1'b0, r_gx}) ? div_rsp.quotient[CW-1:0] : r_gx;
    assign qclamp_y = (div_rsp.quotient < {1'b0, r_gy}) ? div_rsp.quotient[CW-1:0] : r_gy;

    // Result fields by source
    always_comb begin
        res_id    = '0;
        res_cnt   = '0;
        res_start = '0;
        case (r_src)
            SRC_TILE: begin
                res_cnt   = 9'(cnt_rdata);
                res_start = 15'(off_rdata);
            end
            SRC_LIST: res_id = lst_rdata;
            default: ;
        endcase
    end

    // Sequencer next state and memory strobes
    always_comb begin
        n_state = r_state;
        n_light_total = r_light_total;
        n_peak = r_peak; n_total = r_total; n_ovf = r_ovf;
        n_gx = r_gx; n_gy = r_gy; n_li = r_li;
        n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1; n_y1 = r_y1;
        n_dsel = r_dsel;
        n_lx = r_lx; n_ly = r_ly; n_ux = r_ux; n_uy = r_uy;
        n_x = r_x; n_y = r_y; n_rowbase = r_rowbase;
        n_t = r_t; n_tile = r_tile; n_taken = r_taken; n_run = r_run;
        n_pass = r_pass; n_src = r_src; n_pstat = r_pstat;

        rect_we = 1'b0; rect_waddr = r_light_total[RAW-1:0];
        rect_re = 1'b0; rect_raddr = r_li[RAW-1:0];
        cnt_we = 1'b0; cnt_waddr = r_t; cnt_wdata = '0;
        cnt_re = 1'b0; cnt_raddr = r_t;
        off_we = 1'b0; off_waddr = r_t; off_wdata = psum;
        off_re = 1'b0; off_raddr = r_tile;
        lst_we = 1'b0; lst_waddr = LAW'(off_rdata - EW'(1)); lst_wdata = 8'(r_li);
        lst_re = 1'b0; lst_raddr = LAW'(idx);

        div_req.start    = 1'b0;
        div_req.dividend = 14'(r_x0);
        div_req.divisor  = tw_eff;

        unique case (r_state)
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_GX: begin
                if (div_rsp.done) begin
                    n_gx = div_rsp.quotient[CW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = 14'(r_vh) + 14'(th_eff) - 14'd1;
                    div_req.divisor  = th_eff;
                    n_state = S_GY;
                end
            end
            S_GY: begin
                if (div_rsp.done) begin
                    n_gy = div_rsp.quotient[CW-1:0];
                    n_t = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                // clear sweep of the count store
                cnt_we = 1'b1;
                if (r_t == TAW'(MAX_TILES - 1)) begin
                    n_pass = 1'b0; n_li = '0; n_taken = '0;
                    n_state = S_LRD;
                end else begin
                    n_t = r_t + TAW'(1);
                end
            end
            S_LRD: begin
                if (r_li >= r_light_total) begin
                    if (!r_pass) begin
                        n_t = '0; n_run = '0;
                        n_state = S_PRD;
                    end else begin
                        n_light_total = '0;
                        n_src = SRC_ZERO;
                        n_pstat = r_ovf ? tlb_pkg::ST_OVF : tlb_pkg::ST_OK;
                        n_state = S_RESP;
                    end
                end else begin
                    rect_re = 1'b1;
                    n_state = S_LGET;
                end
            end
            S_LGET: begin
                if ((rw_w < r_rw) && (rw_h < r_rh)) begin
                    n_li = r_li + LTW'(1);
                    n_state = S_LRD;
                end else begin
                    n_x0 = rx0; n_y0 = ry0; n_x1 = rx1; n_y1 = ry1;
                    div_req.start    = 1'b1;
                    div_req.dividend = 14'(rx0);
                    div_req.divisor  = tw_eff;
                    n_dsel = 2'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // tile bounds, one divide after another
                if (div_rsp.done) begin
                    n_dsel = r_dsel + 2'd1;
                    case (r_dsel)
                        2'd0: begin
                            n_lx = qclamp_x;
                            div_req.start    = 1'b1;
                            div_req.dividend = 14'(r_y0);
                            div_req.divisor  = th_eff;
                        end
                        2'd1: begin
                            n_ly = qclamp_y;
                            div_req.start    = 1'b1;
                            div_req.dividend = 14'(r_x1) + 14'(tw_eff) - 14'd1;
                            div_req.divisor  = tw_eff;
                        end
                        2'd2: begin
                            n_ux = qclamp_x;
                            div_req.start    = 1'b1;
                            div_req.dividend = 14'(r_y1) + 14'(th_eff) - 14'd1;
                            div_req.divisor  = th_eff;
                        end
                        default: begin
                            n_uy = qclamp_y;
                            n_state = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_rowbase = PW'(r_ly) * PW'(r_gx);
                n_x = r_lx;
                n_y = r_ly;
                n_state = S_TILE;
            end
            S_TILE: begin
                if (r_y >= r_uy) begin
                    n_li = r_li + LTW'(1);
                    n_state = S_LRD;
                end else if (r_x >= r_ux) begin
                    n_y = r_y + CW'(1);
                    n_rowbase = r_rowbase + PW'(r_gx);
                    n_x = r_lx;
                end else if ((tnum >= PW'(MAX_TILES)) || (r_taken >= EW'(MAX_ENTRIES))) begin
                    n_ovf = 1'b1;
                    n_x = r_x + CW'(1);
                end else begin
                    n_taken = r_taken + EW'(1);
                    n_tile = tnum[TAW-1:0];
                    cnt_raddr = tnum[TAW-1:0];
                    off_raddr = tnum[TAW-1:0];
                    cnt_re = !r_pass;
                    off_re = r_pass;
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (!r_pass) begin
                    cnt_we = 1'b1;
                    cnt_waddr = r_tile;
                    cnt_wdata = cnt_rdata + NCW'(1);
                end else if (off_rdata != '0) begin
                    off_we = 1'b1;
                    off_waddr = r_tile;
                    off_wdata = off_rdata - EW'(1);
                    lst_we = 1'b1;
                end
                n_x = r_x + CW'(1);
                n_state = S_TILE;
            end
            S_PRD: begin
                cnt_re = 1'b1;
                n_state = S_PWR;
            end
            S_PWR: begin
                // running end offsets and peak count
                off_we = 1'b1;
                n_run = psum;
                if (cnt_rdata > r_peak) begin
                    n_peak = cnt_rdata;
                end
                if (r_t == TAW'(MAX_TILES - 1)) begin
                    n_total = psum;
                    n_pass = 1'b1; n_li = '0; n_taken = '0;
                    n_state = S_LRD;
                end else begin
                    n_t = r_t + TAW'(1);
                    n_state = S_PRD;
                end
            end
            default: ;
        endcase

        // New command
        if (acc) begin
            n_src = SRC_ZERO;
            n_state = S_RESP;
            unique case (cmd)
                tlb_pkg::CMD_LOAD: begin
                    if (32'(r_light_total) < 32'(MAX_LIGHTS)) begin
                        rect_we = 1'b1;
                        n_light_total = r_light_total + LTW'(1);
                        n_pstat = tlb_pkg::ST_OK;
                    end else begin
                        n_pstat = tlb_pkg::ST_FULL;
                    end
                end
                tlb_pkg::CMD_BUILD: begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 14'(r_vw) + 14'(tw_eff) - 14'd1;
                    div_req.divisor  = tw_eff;
                    n_ovf = 1'b0;
                    n_peak = '0;
                    n_state = S_GX;
                end
                tlb_pkg::CMD_RTILE: begin
                    if (32'(idx) < 32'(MAX_TILES)) begin
                        cnt_re = 1'b1; cnt_raddr = TAW'(idx);
                        off_re = 1'b1; off_raddr = TAW'(idx);
                        n_src = SRC_TILE;
                        n_pstat = r_ovf ? tlb_pkg::ST_OVF : tlb_pkg::ST_OK;
                    end else begin
                        n_pstat = tlb_pkg::ST_RANGE;
                    end
                end
                default: begin
                    if ((32'(idx) < 32'(r_total)) && (32'(idx) < 32'(MAX_ENTRIES))) begin
                        lst_re = 1'b1;
                        n_src = SRC_LIST;
                        n_pstat = r_ovf ? tlb_pkg::ST_OVF : tlb_pkg::ST_OK;
                    end else begin
                        n_pstat = tlb_pkg::ST_RANGE;
                    end
                end
            endcase
        end
    end

    // State, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tw <= 9'd16; r_th <= 9'd16;
            r_vw <= 13'd1920; r_vh <= 13'd1080;
            r_rw <= '0; r_rh <= '0;
            r_light_total <= '0;
            r_peak <= '0; r_total <= '0; r_ovf <= 1'b0;
            r_mvalid <= 1'b0;
            r_pass <= 1'b0;
        end else begin
            r_state <= n_state;
            r_light_total <= n_light_total;
            r_peak <= n_peak; r_total <= n_total; r_ovf <= n_ovf;
            r_pass <= n_pass;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlb_pkg::CFG_TILE_W: r_tw <= i_cfg_wdata[8:0];
                    tlb_pkg::CFG_TILE_H: r_th <= i_cfg_wdata[8:0];
                    tlb_pkg::CFG_VIEW_W: r_vw <= i_cfg_wdata;
                    tlb_pkg::CFG_VIEW_H: r_vh <= i_cfg_wdata;
                    tlb_pkg::CFG_REJ_W:  r_rw <= i_cfg_wdata;
                    tlb_pkg::CFG_REJ_H:  r_rh <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if ((r_state == S_RESP) && out_free) begin
                r_mvalid <= 1'b1;
                r_mdata  <= {6'd0, r_pstat, 15'(r_total), 9'(r_peak),
                             res_start, res_cnt, res_id};
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
        r_gx <= n_gx; r_gy <= n_gy; r_li <= n_li;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_dsel <= n_dsel;
        r_lx <= n_lx; r_ly <= n_ly; r_ux <= n_ux; r_uy <= n_uy;
        r_x <= n_x; r_y <= n_y; r_rowbase <= n_rowbase;
        r_t <= n_t; r_tile <= n_tile; r_taken <= n_taken; r_run <= n_run;
        r_src <= n_src; r_pstat <= n_pstat;
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // Light rectangle store
    tlb_ram #(.WIDTH(4 * CW), .DEPTH(MAX_LIGHTS)) u_rect (
        .i_clk(i_clk), .i_we(rect_we), .i_waddr(rect_waddr),
        .i_wdata(s_axis_tdata[4*CW-1:0]),
        .i_re(rect_re), .i_raddr(rect_raddr), .o_rdata(rect_rdata)
    );

    // Per-tile counts
    tlb_ram #(.WIDTH(NCW), .DEPTH(MAX_TILES)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_re(cnt_re), .i_raddr(cnt_raddr), .o_rdata(cnt_rdata)
    );

    // Per-tile offsets
    tlb_ram #(.WIDTH(EW), .DEPTH(MAX_TILES)) u_off (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(off_wdata),
        .i_re(off_re), .i_raddr(off_raddr), .o_rdata(off_rdata)
    );

    // Flat light list
    tlb_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_lst (
        .i_clk(i_clk), .i_we(lst_we), .i_waddr(lst_waddr), .i_wdata(lst_wdata),
        .i_re(lst_re), .i_raddr(lst_raddr), .o_rdata(lst_rdata)
    );

    // Shared divider for grid size and tile bounds
    tlb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

endmodule
`default_nettype wire
